### src/kcl_pkg.sv
// Shared types and codes for the keypad code lock.
`default_nettype none

package kcl_pkg;

  localparam int unsigned KEY_W       = 4;
  localparam int unsigned CODE_LEN_W  = 5;
  localparam int unsigned CODE_KEYS_W = 64;
  localparam int unsigned EVENT_W     = 3;
  localparam int unsigned COUNT_OUT_W = 5;

  // Keys with a special meaning
  localparam logic [KEY_W-1:0] KEY_ENTER = 4'd3;
  localparam logic [KEY_W-1:0] KEY_CLEAR = 4'd7;

  // Result event codes
  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DIGIT    = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CLEARED  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_UNLOCKED = 3'd3;
  localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd4;
  localparam logic [EVENT_W-1:0] EV_FULL     = 3'd5;

  // Configuration register indexes
  localparam logic REG_CODE_LENGTH = 1'b0;
  localparam logic REG_CODE_KEYS   = 1'b1;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CLEAR,
    KIND_ENTER,
    KIND_DIGIT
  } kcl_kind_t;

  typedef struct packed {
    kcl_kind_t        kind;
    logic [KEY_W-1:0] key;
  } kcl_cmd_t;

  typedef struct packed {
    logic [CODE_LEN_W-1:0]  code_length;
    logic [CODE_KEYS_W-1:0] code_keys;
  } kcl_cfg_t;

  typedef struct packed {
    logic [EVENT_W-1:0]     event_res;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   unlock;
  } kcl_result_t;

endpackage

`default_nettype wire

### src/keypad_code_lock.sv
// Keypad code lock: takes one keypad scan per item and reports one event per scan.
// The input channel carries one scan per item: in_tuser is the pressed flag and
// in_tdata[3:0] the row-major key index. A press counts only when the previous
// scan was not a press of the same key; key 7 clears the entry, key 3 checks it
// against the programmed code and clears it, any other key appends a digit.
// Every scan gives exactly one result item on the output channel: event code,
// digits now held, and an unlock pulse on a correct code.
// The code is programmed over the APB port: code_length at 0x0, code_keys at
// 0x8 (64 bits, first digit in the low nibble); reprogram only while idle.
// On its way the scan waits in the command queue and is then written into the
// back end's output register, from which its result can be taken. One scan is
// taken every cycle; the two-entry queue and output register keep that rate
// while the receiver takes every cycle.
// When the receiver stalls the result holds, the queue fills and in_tready drops
// once it holds two scans. Reset empties the queue, clears the entry and the
// last-key memory, and restores the code to length 3, digits 5 5 5.
`default_nettype none

module keypad_code_lock import kcl_pkg::*; #(
  parameter int unsigned ENTRY_CAP = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [3:0] key_index, [7:4] zero
  input  wire logic        in_tuser,      // [0] key_pressed
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,     // [2:0] event_res, [7:3] entry_count, [8] unlock
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [CODE_LEN_W-1:0]  code_length_r;
  logic [CODE_KEYS_W-1:0] code_keys_r;
  kcl_cfg_t               cfg;
  logic                   cfg_wr;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  kcl_cmd_t               push_cmd;
  kcl_cmd_t               pop_cmd;
  kcl_result_t            res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_CODE_KEYS) ? code_keys_r
                                                      : 64'(code_length_r);
  assign cfg.code_length = code_length_r;
  assign cfg.code_keys   = code_keys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= 5'd3;
      code_keys_r   <= 64'h555;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == REG_CODE_LENGTH) begin
        code_length_r <= cfg_pwdata[CODE_LEN_W-1:0];
      end else begin
        code_keys_r <= cfg_pwdata;
      end
    end
  end

  kcl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .key_pressed (in_tuser),
    .key_index   (in_tdata[KEY_W-1:0]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  kcl_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  kcl_back #(
    .ENTRY_CAP (ENTRY_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'd0, res.unlock, res.entry_count, res.event_res};

  // Unlock pulses only with the unlocked event
  a_unlock_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.unlock |-> res.event_res == EV_UNLOCKED)
    else $error("unlock without unlocked event");

  // Clear and enter always leave an empty entry
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.event_res == EV_CLEARED || res.event_res == EV_WRONG ||
                   res.event_res == EV_UNLOCKED) |-> res.entry_count == '0)
    else $error("entry not cleared");

  // The entry never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.entry_count <= COUNT_OUT_W'(ENTRY_CAP))
    else $error("entry count above capacity");

  // A full queue stops the input side
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_tready && !q_push)
    else $error("push into full queue");

endmodule

`default_nettype wire

### src/kcl_front.sv
// Scan front end: edge-detects key presses and classifies each item for the queue.
`default_nettype none

module kcl_front import kcl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             key_pressed,
  input  wire logic [KEY_W-1:0] key_index,
  input  wire logic             q_full,
  output logic                  q_push,
  output kcl_cmd_t              q_cmd
);

  logic             prev_valid_r;
  logic [KEY_W-1:0] prev_key_r;
  logic             new_press;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign new_press = key_pressed && (!prev_valid_r || (key_index != prev_key_r));

  always_comb begin
    q_cmd.key = key_index;
    if (!new_press) begin
      q_cmd.kind = KIND_NONE;
    end else if (key_index == KEY_CLEAR) begin
      q_cmd.kind = KIND_CLEAR;
    end else if (key_index == KEY_ENTER) begin
      q_cmd.kind = KIND_ENTER;
    end else begin
      q_cmd.kind = KIND_DIGIT;
    end
  end

  // An idle scan forgets the last key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      prev_key_r   <= '0;
    end else if (q_push) begin
      prev_valid_r <= key_pressed;
      if (key_pressed) begin
        prev_key_r <= key_index;
      end
    end
  end

endmodule

`default_nettype wire

### src/kcl_fifo.sv
// Two-entry command queue between the scan front end and the entry back end.
`default_nettype none

module kcl_fifo import kcl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire kcl_cmd_t push_cmd,
  input  wire logic     pop,
  output kcl_cmd_t      pop_cmd,
  output logic          full,
  output logic          empty
);

  kcl_cmd_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### src/kcl_back.sv
// Entry back end: holds the typed digits, checks the code and registers each result.
`default_nettype none

module kcl_back import kcl_pkg::*; #(
  parameter int unsigned ENTRY_CAP = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire kcl_cfg_t    cfg,
  input  wire logic        q_empty,
  input  wire kcl_cmd_t    q_cmd,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output kcl_result_t      out_res
);

  localparam int unsigned CNT_W = $clog2(ENTRY_CAP + 1);
  localparam int unsigned IDX_W = (ENTRY_CAP > 1) ? $clog2(ENTRY_CAP) : 1;

  logic [KEY_W-1:0]   digits_r [ENTRY_CAP];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  kcl_result_t        res_r;
  kcl_result_t        res_nxt;
  logic               wr_digit;
  logic               digits_ok;
  logic               code_match;
  logic [IDX_W-1:0]   wr_idx;

  assign q_pop     = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign wr_idx    = count_r[IDX_W-1:0];

  // Compare every held digit against its code nibble in parallel
  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < ENTRY_CAP; i++) begin
      if ((CNT_W'(i) < count_r) && (digits_r[i] != cfg.code_keys[4*i +: KEY_W])) begin
        digits_ok = 1'b0;
      end
    end
  end

  assign code_match = digits_ok && (COUNT_OUT_W'(count_r) == cfg.code_length);

  always_comb begin
    count_nxt         = count_r;
    wr_digit          = 1'b0;
    res_nxt.event_res = EV_NONE;
    res_nxt.unlock    = 1'b0;
    unique case (q_cmd.kind)
      KIND_NONE: begin
        res_nxt.event_res = EV_NONE;
      end
      KIND_CLEAR: begin
        count_nxt         = '0;
        res_nxt.event_res = EV_CLEARED;
      end
      KIND_ENTER: begin
        count_nxt         = '0;
        res_nxt.event_res = code_match ? EV_UNLOCKED : EV_WRONG;
        res_nxt.unlock    = code_match;
      end
      KIND_DIGIT: begin
        if (count_r < CNT_W'(ENTRY_CAP)) begin
          wr_digit          = 1'b1;
          count_nxt         = count_r + CNT_W'(1);
          res_nxt.event_res = EV_DIGIT;
        end else begin
          res_nxt.event_res = EV_FULL;
        end
      end
      default: begin
        res_nxt.event_res = EV_NONE;
      end
    endcase
    res_nxt.entry_count = COUNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (q_pop && wr_digit) begin
      digits_r[wr_idx] <= q_cmd.key;
    end
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### dv/keypad_code_lock_tb.sv
// Self-checking testbench for the keypad code lock: scan stream, result stream, APB code writes.
`default_nettype none

module keypad_code_lock_tb import kcl_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRY_CAP = 16;

  // Tracks the lock's entry and code, and holds the events still owed by the block.
  class lock_scoreboard;
    logic [CODE_LEN_W-1:0]  code_len;
    logic [CODE_KEYS_W-1:0] code_keys;
    bit                     held_valid;
    logic [KEY_W-1:0]       held_key;
    logic [KEY_W-1:0]       digits [16];
    logic [COUNT_OUT_W-1:0] count;
    kcl_result_t            owed [$];
    int                     errors;

    function new();
      code_len   = 5'd3;
      code_keys  = 64'h555;
      held_valid = 1'b0;
      held_key   = '0;
      count      = '0;
      errors     = 0;
    endfunction

    function logic [EVENT_W-1:0] note_scan(bit pressed, logic [KEY_W-1:0] key);
      kcl_result_t r;
      bit          match;
      r.event_res = EV_NONE;
      r.unlock    = 1'b0;
      if (!pressed) begin
        held_valid = 1'b0;
      end else if (!held_valid || key != held_key) begin
        held_valid = 1'b1;
        held_key   = key;
        if (key == KEY_CLEAR) begin
          count       = '0;
          r.event_res = EV_CLEARED;
        end else if (key == KEY_ENTER) begin
          match = (count == code_len);
          for (int i = 0; i < 16; i++)
            if (i < count && digits[i] != code_keys[4*i +: 4]) match = 1'b0;
          r.event_res = match ? EV_UNLOCKED : EV_WRONG;
          r.unlock    = match;
          count       = '0;
        end else if (count < ENTRY_CAP) begin
          digits[count] = key;
          count         = count + 1'b1;
          r.event_res   = EV_DIGIT;
        end else begin
          r.event_res = EV_FULL;
        end
      end
      r.entry_count = count;
      owed.push_back(r);
      return r.event_res;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [15:0] tdata);
      kcl_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected: actual %h", $time, tdata);
        return;
      end
      want = owed.pop_front();
      compare_field("event_res", 8'(want.event_res), 8'(tdata[2:0]));
      compare_field("entry_count", 8'(want.entry_count), 8'(tdata[7:3]));
      compare_field("unlock", 8'(want.unlock), 8'(tdata[8]));
      compare_field("padding", 8'd0, 8'(tdata[15:9]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [3:0] key_index, [7:4] zero
  logic        in_tuser;   // [0] key_pressed
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [2:0] event_res, [7:3] entry_count, [8] unlock
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  lock_scoreboard sb = new();

  int live_scans;
  int sent_scans;
  int burst_left;
  int results_seen;
  int hold_left;
  bit long_hold_done;
  int rx_mode;
  int rx_cycle;

  keypad_code_lock #(.ENTRY_CAP(ENTRY_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_scan(bit pressed, logic [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= pressed;
    in_tdata  <= {4'b0000, key};
    do @(posedge clk); while (!in_tready);
    sent_scans++;
    if (sb.note_scan(pressed, key) != EV_NONE) live_scans++;
    @(negedge clk);
  endtask

  // Release the key first where the same key is still held, and now and then anyway.
  task automatic press_key(logic [KEY_W-1:0] key);
    if ((sb.held_valid && sb.held_key == key) || $urandom_range(0, 3) == 0)
      send_scan(1'b0, KEY_W'($urandom_range(0, 15)));
    send_scan(1'b1, key);
    if ($urandom_range(0, 7) == 0) send_scan(1'b1, key);
  endtask

  function automatic logic [KEY_W-1:0] any_digit();
    logic [KEY_W-1:0] k;
    do k = KEY_W'($urandom_range(0, 15)); while (k == KEY_ENTER || k == KEY_CLEAR);
    return k;
  endfunction

  // Called at a falling edge; returns at a falling edge with the bus idle.
  task automatic apb_write(logic reg_idx, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drain the block, then reprogram the code.
  task automatic set_code(logic [CODE_LEN_W-1:0] len, logic [CODE_KEYS_W-1:0] keys);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_write(REG_CODE_LENGTH, 64'(len));
    sb.code_len = len;
    apb_write(REG_CODE_KEYS, keys);
    sb.code_keys = keys;
  endtask

  // One attempt at the lock: mostly the code, sometimes spoiled, flooded or noise.
  task automatic try_code();
    int mode;
    int len;
    int spoil;
    int n;
    logic [KEY_W-1:0] k;
    mode = $urandom_range(0, 9);
    len  = (sb.code_len > ENTRY_CAP) ? ENTRY_CAP : sb.code_len;
    case (mode)
      5, 6, 7: begin
        spoil = (len > 0) ? $urandom_range(0, len - 1) : 0;
        if (mode == 7) begin
          n = $urandom_range(1, 4);
          repeat (n) press_key(any_digit());
          press_key(KEY_CLEAR);
        end
        for (int i = 0; i < len; i++) begin
          k = sb.code_keys[4*i +: 4];
          if (mode == 5 && i == spoil) k = k ^ KEY_W'($urandom_range(1, 15));
          if (!(mode == 6 && i == spoil && $urandom_range(0, 1) == 0)) press_key(k);
        end
        if (mode == 6 && $urandom_range(0, 1) == 0) press_key(any_digit());
        press_key(KEY_ENTER);
      end
      8: begin
        n = $urandom_range(ENTRY_CAP + 1, ENTRY_CAP + 4);
        repeat (n) press_key(any_digit());
        press_key(($urandom_range(0, 1) == 0) ? KEY_ENTER : KEY_CLEAR);
      end
      9: begin
        n = $urandom_range(1, 8);
        repeat (n) send_scan(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 15)));
      end
      default: begin
        for (int i = 0; i < len; i++) press_key(sb.code_keys[4*i +: 4]);
        press_key(KEY_ENTER);
      end
    endcase
  endtask

  // Receiver: the ready pattern is redrawn at random from four modes; a long hold-off once, after 120 results.
  initial begin
    out_tready     = 1'b0;
    rx_mode        = 0;
    rx_cycle       = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (!long_hold_done && results_seen >= 120 && in_tvalid) begin
        hold_left      = 80;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (rx_cycle % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
      results_seen++;
    end
  end

  // pressed/key pairs: idles with all key bits, the default code, repeats, clear, wrong codes
  localparam bit [4:0] DIRECTED [21] = '{
    {1'b0, 4'd15}, {1'b1, 4'd5}, {1'b1, 4'd5}, {1'b0, 4'd0}, {1'b1, 4'd5},
    {1'b0, 4'd10}, {1'b1, 4'd5}, {1'b1, KEY_ENTER}, {1'b1, 4'd0}, {1'b1, 4'd15},
    {1'b1, KEY_CLEAR}, {1'b1, KEY_ENTER}, {1'b1, KEY_ENTER}, {1'b0, 4'd3},
    {1'b1, KEY_ENTER}, {1'b1, 4'd5}, {1'b0, 4'd5}, {1'b1, 4'd5}, {1'b1, KEY_ENTER},
    {1'b1, KEY_CLEAR}, {1'b1, KEY_CLEAR}
  };

  initial begin
    int phase_start;
    int phase;
    logic [CODE_LEN_W-1:0]  len;
    logic [CODE_KEYS_W-1:0] keys;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    live_scans   = 0;
    sent_scans   = 0;
    burst_left   = 0;
    results_seen = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_scan(DIRECTED[i][4], DIRECTED[i][3:0]);

    live_scans = 0;
    phase      = 0;
    while (sent_scans < 400) begin
      case (phase)
        0: begin len = 5'd3; keys = 64'h555; end
        1: begin len = 5'd0; keys = {$urandom, $urandom}; end
        2: begin len = 5'd16; keys = '1; end
        3: begin len = 5'd16; keys = '0; end
        4: begin len = 5'd31; keys = {$urandom, $urandom}; end
        5: begin len = 5'd4; keys = 64'h7_3_9_1; end
        6: begin len = 5'd17; keys = 64'h0123_4568_9ABC_DEF0; end
        default: begin
          len  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 6));
          keys = {$urandom, $urandom};
        end
      endcase
      if (phase > 0) set_code(len, keys);
      phase_start = live_scans;
      while (live_scans - phase_start < 30 && sent_scans < 400) try_code();
      phase++;
    end

    in_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
